// File: sv/fpss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpss_pkg
// Shared constants and types for the five-point cross smoothing filter.
// ----------------------------------------------------------------------------
package fpss_pkg;

    localparam int PIX_W       = 16;
    localparam int SUM_W       = PIX_W + 3;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_ADDR_W  = 2;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MIN_DIM     = 3;
    localparam int DIM_RESET   = 1024;
    localparam int MEAN_TAPS   = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BORDER_ZERO  = 2'd2;

    typedef struct packed {
        logic take;
        logic flushing;
        logic has_out;
        logic border;
        logic eof;
        logic last_col;
    } t_scan_info;

    typedef struct packed {
        logic             border;
        logic [PIX_W-1:0] border_val;
        logic             eof;
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] pix;
    } t_cross;

endpackage
`default_nettype wire

// File: sv/fpss_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpss interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface fpss_pix_if import fpss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             flush;

    modport source (output valid, output pixel_value, output flush, input ready);
    modport sink   (input valid, input pixel_value, input flush, output ready);
endinterface

interface fpss_res_if import fpss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] smoothed_value;
    logic             end_of_frame;

    modport source (output valid, output smoothed_value, output end_of_frame, input ready);
    modport sink   (input valid, input smoothed_value, input end_of_frame, output ready);
endinterface

interface fpss_cfg_if import fpss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// File: sv/fpss_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpss_line_store
// One row of pixels: single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module fpss_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: sv/fpss_scan_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpss_scan_ctrl
// Column and row counters, geometry clamp, border and flush-phase decode.
// ----------------------------------------------------------------------------
module fpss_scan_ctrl import fpss_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DATA_W-1:0] i_frame_width,
    input  logic [CFG_DATA_W-1:0] i_frame_height,
    input  logic                  i_flush,
    input  logic                  i_accept,
    output t_scan_info            o_scan,
    output logic [CW-1:0]         o_col,
    output logic [CW-1:0]         o_next_col
);

    localparam int LW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

    logic [CW-1:0]         r_col;
    logic [CW-1:0]         n_col;
    logic [CFG_DATA_W-1:0] r_row;
    logic [CFG_DATA_W-1:0] n_row;
    logic [LW-1:0]         fw_ext;
    logic [LW-1:0]         w_use;
    logic [CFG_DATA_W-1:0] h_use;
    logic [CFG_DATA_W-1:0] out_row;
    logic                  last_col;
    logic                  flushing;

    always_comb begin
        fw_ext = LW'(i_frame_width);
        if (fw_ext < LW'(MIN_DIM)) begin
            w_use = LW'(MIN_DIM);
        end else if (fw_ext > LW'(MAX_WIDTH)) begin
            w_use = LW'(MAX_WIDTH);
        end else begin
            w_use = fw_ext;
        end

        if (i_frame_height < CFG_DATA_W'(MIN_DIM)) begin
            h_use = CFG_DATA_W'(MIN_DIM);
        end else if (i_frame_height > CFG_DATA_W'(MAX_HEIGHT)) begin
            h_use = CFG_DATA_W'(MAX_HEIGHT);
        end else begin
            h_use = i_frame_height;
        end

        last_col = LW'(r_col) >= (w_use - LW'(1));
        flushing = r_row >= h_use;
        out_row  = flushing ? (h_use - CFG_DATA_W'(1)) : (r_row - CFG_DATA_W'(1));

        o_scan.take     = i_flush == flushing;
        o_scan.flushing = flushing;
        o_scan.has_out  = flushing || (r_row != '0);
        o_scan.border   = (out_row == '0) || (out_row >= (h_use - CFG_DATA_W'(1)))
                          || (r_col == '0) || last_col;
        o_scan.eof      = flushing && last_col;
        o_scan.last_col = last_col;

        n_col = last_col ? '0 : (r_col + CW'(1));
        n_row = !last_col ? r_row : (flushing ? '0 : (r_row + CFG_DATA_W'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept && o_scan.take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col      = r_col;
    assign o_next_col = n_col;

endmodule
`default_nettype wire

// File: sv/fpss_mean5.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpss_mean5
// Five-tap sum, divide by five (reciprocal multiply plus one correction),
// border select and output register. Three stages, each with its own valid.
// ----------------------------------------------------------------------------
module fpss_mean5 import fpss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_cross            i_cross,
    fpss_res_if.source        o_res
);

    localparam int PW = 2 * SUM_W;
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / MEAN_TAPS);

    logic             r_s2_valid;
    logic [SUM_W-1:0] r_s2_sum;
    logic             r_s2_border;
    logic [PIX_W-1:0] r_s2_bval;
    logic             r_s2_eof;

    logic             r_s3_valid;
    logic [SUM_W-1:0] r_s3_sum;
    logic [SUM_W-1:0] r_s3_q0;
    logic             r_s3_border;
    logic [PIX_W-1:0] r_s3_bval;
    logic             r_s3_eof;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_value;
    logic             r_out_eof;

    logic             s2_adv;
    logic             s3_adv;
    logic             out_adv;
    logic [SUM_W-1:0] n_sum;
    logic [PW-1:0]    prod;
    logic [SUM_W-1:0] five_q;
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] mean;
    logic [PIX_W-1:0] n_value;

    assign out_adv = !r_out_valid || o_res.ready;
    assign s3_adv  = !r_s3_valid || out_adv;
    assign s2_adv  = !r_s2_valid || s3_adv;
    assign o_ready = s2_adv;

    always_comb begin
        n_sum = SUM_W'(i_cross.centre) + SUM_W'(i_cross.up) + SUM_W'(i_cross.left)
              + SUM_W'(i_cross.right) + SUM_W'(i_cross.pix);
        prod   = PW'(r_s2_sum) * PW'(RECIP);
        // q0 is floor(sum/5) or one less
        five_q = (r_s3_q0 << 2) + r_s3_q0;
        rem    = r_s3_sum - five_q;
        mean   = r_s3_q0 + SUM_W'(rem >= SUM_W'(MEAN_TAPS));
        n_value = r_s3_border ? r_s3_bval : mean[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_adv) begin
                r_s2_valid <= i_valid;
            end
            if (s3_adv) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_s2_sum    <= n_sum;
            r_s2_border <= i_cross.border;
            r_s2_bval   <= i_cross.border_val;
            r_s2_eof    <= i_cross.eof;
        end
        if (s3_adv) begin
            r_s3_sum    <= r_s2_sum;
            r_s3_q0     <= prod[PW-1:SUM_W];
            r_s3_border <= r_s2_border;
            r_s3_bval   <= r_s2_bval;
            r_s3_eof    <= r_s2_eof;
        end
        if (out_adv) begin
            r_out_value <= n_value;
            r_out_eof   <= r_s3_eof;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.smoothed_value = r_out_value;
    assign o_res.end_of_frame   = r_out_eof;

endmodule
`default_nettype wire

// File: sv/five_point_stencil_smoother.sv
`default_nettype none
// ----------------------------------------------------------------------------
// five_point_stencil_smoother
// Five-point cross mean filter over a raster-order pixel stream.
//
// i_pix takes one pixel per transaction in raster order; flush transactions
// (flush = 1) follow the last pixel and emit the final row, one per
// transaction. o_res returns one filtered pixel per transaction, one row
// behind the input; end_of_frame marks the last pixel of the frame.
// i_cfg writes frame_width (0), frame_height (1) and border_zero (2); it is
// always ready; the user must write it only while the filter is idle.
// The block does not enforce this. Throughput is one transaction per cycle
// while o_res is ready: two line stores are each read once and written once
// per pixel, the read being a one-column prefetch. Each result passes the
// prefetch register, sum, reciprocal multiply and correction/output register.
// Reset clears counters, pipeline valids and config (1024 x 1024, pass-through
// borders); line stores are not cleared and are filled by the first row.
// When o_res stalls, the four pipeline stages keep filling, and i_pix drops
// ready only once every stage holds a result.
// ----------------------------------------------------------------------------
module five_point_stencil_smoother import fpss_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpss_pix_if.sink   i_pix,
    fpss_res_if.source o_res,
    fpss_cfg_if.sink   i_cfg
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SB = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic                  r_border_zero;

    t_scan_info    scan;
    logic [CW-1:0] col;
    logic [CW-1:0] next_col;

    logic          pix_acc;
    logic          item_go;
    logic          s1_adv;
    logic          s2_ready;
    logic [SB-1:0] pix_in;
    logic [SB-1:0] up_q;
    logic [SB-1:0] mid_q;
    logic [SB-1:0] r_left;
    logic [SB-1:0] n_left;

    logic          r_s1_valid;
    logic [SB-1:0] r_s1_centre;
    logic [SB-1:0] r_s1_up;
    logic [SB-1:0] r_s1_left;
    logic [SB-1:0] r_s1_pix;
    logic          r_s1_border;
    logic          r_s1_eof;
    logic          r_s1_bzero;
    t_cross        s1_taps;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DATA_W'(DIM_RESET);
            r_frame_height <= CFG_DATA_W'(DIM_RESET);
            r_border_zero  <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.addr)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                CFG_BORDER_ZERO:  r_border_zero  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    fpss_scan_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_flush        (i_pix.flush),
        .i_accept       (pix_acc),
        .o_scan         (scan),
        .o_col          (col),
        .o_next_col     (next_col)
    );

    assign s1_adv      = !r_s1_valid || s2_ready;
    assign i_pix.ready = s1_adv;
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign item_go     = pix_acc && scan.take;
    assign pix_in      = i_pix.pixel_value[SB-1:0];

    // stores write column col and prefetch the next column
    fpss_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (SB)
    ) u_upper_store (
        .i_clk   (i_clk),
        .i_we    (item_go && !scan.flushing),
        .i_waddr (col),
        .i_wdata (mid_q),
        .i_re    (item_go),
        .i_raddr (next_col),
        .o_rdata (up_q)
    );

    fpss_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (SB)
    ) u_middle_store (
        .i_clk   (i_clk),
        .i_we    (item_go && !scan.flushing),
        .i_waddr (col),
        .i_wdata (pix_in),
        .i_re    (item_go),
        .i_raddr (next_col),
        .o_rdata (mid_q)
    );

    assign n_left = scan.last_col ? '0 : mid_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (item_go) begin
                r_left <= n_left;
            end
            if (s1_adv) begin
                r_s1_valid <= item_go && scan.has_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_go) begin
            r_s1_centre <= mid_q;
            r_s1_up     <= up_q;
            r_s1_left   <= r_left;
            r_s1_pix    <= pix_in;
            r_s1_border <= scan.border;
            r_s1_eof    <= scan.eof;
            r_s1_bzero  <= r_border_zero;
        end
    end

    // right neighbor is the prefetched middle-row word, held until next accept
    always_comb begin
        s1_taps.border     = r_s1_border;
        s1_taps.border_val = r_s1_bzero ? '0 : PIX_W'(r_s1_centre);
        s1_taps.eof        = r_s1_eof;
        s1_taps.centre     = PIX_W'(r_s1_centre);
        s1_taps.up         = PIX_W'(r_s1_up);
        s1_taps.left       = PIX_W'(r_s1_left);
        s1_taps.right      = PIX_W'(mid_q);
        s1_taps.pix        = PIX_W'(r_s1_pix);
    end

    fpss_mean5 u_mean5 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (s2_ready),
        .i_cross (s1_taps),
        .o_res   (o_res)
    );

    a_store_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_go && !scan.flushing) |-> (col != next_col))
        else $error("line store write and prefetch hit the same column");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |-> !pix_acc)
        else $error("pixel accepted while stage 1 holds its prefetched neighbor");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_go && scan.last_col) |=> (col == '0))
        else $error("column count did not wrap after the last column");

endmodule
`default_nettype wire
